>>> hdl/pcrt_pkg.sv
// Shared types, widths, register indexes and constants for the point cloud
// rigid transform. Depends on nothing; every other file imports it.
package pcrt_pkg;

  localparam int CW     = 32;          // input coordinate, Q16.16
  localparam int QW     = 16;          // quaternion part, Q2.14
  localparam int TW     = 32;          // translation, Q16.16
  localparam int SW     = 10;          // scale factor
  localparam int OW     = 48;          // output coordinate
  localparam int FRAC   = 29;          // fraction bits of matrix entries
  localparam int RW     = FRAC + 2;    // rotation entry, signed
  localparam int EW     = FRAC + 2;    // extrinsic entry, signed
  localparam int QQW    = CW + 1;      // point after extrinsic
  localparam int UW     = QQW + 2;     // rotated and shifted point
  localparam int ACW    = 64;          // dot product accumulators
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam bit USE_EXT_DEF = 1'b1;

  localparam logic [CFG_AW-1:0] REG_QUAT_W = 3'd0;
  localparam logic [CFG_AW-1:0] REG_QUAT_X = 3'd1;
  localparam logic [CFG_AW-1:0] REG_QUAT_Y = 3'd2;
  localparam logic [CFG_AW-1:0] REG_QUAT_Z = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SHIFT_X = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SHIFT_Y = 3'd5;
  localparam logic [CFG_AW-1:0] REG_SHIFT_Z = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SCALE = 3'd7;

  typedef logic [8:0][RW-1:0] rot_mat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } colour_t;

  localparam logic [RW-1:0] ROT_ONE = RW'(1) << FRAC;
  localparam rot_mat_t ROT_ID = '{0: ROT_ONE, 4: ROT_ONE, 8: ROT_ONE, default: '0};

  // 15-digit decimal fraction to Q.29, rounded to nearest
  function automatic logic signed [EW-1:0] epos(input logic [63:0] digits);
    logic [63:0] t;
    t = (digits * 64'd16384 + 64'd15258789062) / 64'd30517578125;
    return $signed(t[EW-1:0]);
  endfunction

  localparam logic signed [EW-1:0] EXT [0:2][0:3] = '{
    '{ epos(64'd241761029007299), -epos(64'd156482265388292),
       epos(64'd957635058606503),  epos(64'd78542236056188) },
    '{-epos(64'd159587283912986), -epos(64'd979884124280077),
      -epos(64'd119829052391907), -epos(64'd78052590612562) },
    '{ epos(64'd957122512360151), -epos(64'd123856382971628),
      -epos(64'd261870373907737), -epos(64'd61252007077847) }
  };

endpackage

>>> hdl/pcrt_if.sv
// Point stream interfaces: input points and transformed output points.
// Depends on pcrt_pkg.
interface pcrt_in_if import pcrt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  logic [7:0]           alpha;
  modport source (output valid, pos_x, pos_y, pos_z, red, green, blue, alpha, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, red, green, blue, alpha, output ready);
endinterface

interface pcrt_out_if import pcrt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] out_x;
  logic signed [OW-1:0] out_y;
  logic signed [OW-1:0] out_z;
  logic [7:0]           out_red;
  logic [7:0]           out_green;
  logic [7:0]           out_blue;
  logic [7:0]           out_alpha;
  modport source (output valid, out_x, out_y, out_z, out_red, out_green, out_blue, out_alpha,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_red, out_green, out_blue, out_alpha,
                output ready);
endinterface

>>> hdl/pcrt_rot_builder.sv
// Builds the rotation matrix from the quaternion with a bit-serial divider,
// one entry after another. Depends on pcrt_pkg.
module pcrt_rot_builder import pcrt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [QW-1:0] qw,
  input  logic signed [QW-1:0] qx,
  input  logic signed [QW-1:0] qy,
  input  logic signed [QW-1:0] qz,
  output rot_mat_t             rot,
  output logic                 busy
);
  localparam int NW  = 2 * QW + 2;    // numerator, signed
  localparam int NNW = 2 * QW + 1;    // norm, unsigned
  localparam int DVW = NW + FRAC;     // dividend
  localparam int PW  = 2 * QW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PROD = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;
  localparam logic [3:0] LAST_ENTRY = 4'd8;

  logic [1:0]           state;
  logic [3:0]           k;
  logic [4:0]           cnt;
  logic [NNW-1:0]       n;
  logic signed [NW-1:0] num [0:8];
  logic signed [NW-1:0] num_next [0:8];
  logic [NNW-1:0]       n_next;
  logic [NNW-1:0]       rem;
  logic [FRAC:0]        dlo;
  logic [FRAC:0]        quo;
  logic                 neg;

  logic signed [PW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic [NW-1:0]        mag;
  logic [DVW-1:0]       dvd;
  logic [NNW:0]         trial;
  logic                 ge;
  logic [FRAC:0]        qfin;

  always_comb begin
    ww = qw * qw; xx = qx * qx; yy = qy * qy; zz = qz * qz;
    xy = qx * qy; wz = qw * qz; xz = qx * qz; wy = qw * qy;
    yz = qy * qz; wx = qw * qx;
    n_next = NNW'($unsigned(ww)) + NNW'($unsigned(xx)) + NNW'($unsigned(yy))
           + NNW'($unsigned(zz));
    num_next[0] = NW'(ww) + NW'(xx) - NW'(yy) - NW'(zz);
    num_next[1] = (NW'(xy) - NW'(wz)) <<< 1;
    num_next[2] = (NW'(xz) + NW'(wy)) <<< 1;
    num_next[3] = (NW'(xy) + NW'(wz)) <<< 1;
    num_next[4] = NW'(ww) - NW'(xx) + NW'(yy) - NW'(zz);
    num_next[5] = (NW'(yz) - NW'(wx)) <<< 1;
    num_next[6] = (NW'(xz) - NW'(wy)) <<< 1;
    num_next[7] = (NW'(yz) + NW'(wx)) <<< 1;
    num_next[8] = NW'(ww) - NW'(xx) - NW'(yy) + NW'(zz);
  end

  always_comb begin
    mag   = num[k] < 0 ? NW'(-num[k]) : NW'(num[k]);
    dvd   = {mag, {FRAC{1'b0}}} + DVW'(n >> 1);
    trial = {rem, dlo[FRAC]};
    ge    = trial >= {1'b0, n};
    qfin  = {quo[FRAC-1:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rot   <= ROT_ID;
      k     <= '0;
      cnt   <= '0;
    end else if (start) begin
      state <= ST_PROD;
    end else begin
      case (state)
        ST_PROD: begin
          n     <= n_next;
          num   <= num_next;
          k     <= '0;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (n == '0) begin
            rot   <= ROT_ID;
            state <= ST_IDLE;
          end else begin
            rem   <= dvd[DVW-1:FRAC+1];
            dlo   <= dvd[FRAC:0];
            neg   <= num[k] < 0;
            quo   <= '0;
            cnt   <= 5'(FRAC);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= ge ? NNW'(trial - {1'b0, n}) : trial[NNW-1:0];
          dlo <= dlo << 1;
          quo <= qfin;
          cnt <= cnt - 5'd1;
          if (cnt == '0) begin
            rot[k] <= neg ? RW'(-$signed({1'b0, qfin})) : RW'({1'b0, qfin});
            if (k == LAST_ENTRY) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + 4'd1;
              state <= ST_LOAD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = state != ST_IDLE;

  a_start_restarts: assert property (@(posedge clk) disable iff (rst)
    start |=> state == ST_PROD) else $error("rebuild did not restart");
  a_last_entry_ends: assert property (@(posedge clk) disable iff (rst)
    (!start && state == ST_DIV && cnt == '0 && k == LAST_ENTRY) |=> state == ST_IDLE)
    else $error("rebuild did not finish after last entry");
  a_entry_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD || state == ST_DIV) |-> k <= LAST_ENTRY)
    else $error("matrix entry index out of range");
endmodule

>>> hdl/pcrt_datapath.sv
// Five-stage point pipeline: extrinsic products, extrinsic sums, rotation
// products, rotation sums plus shift, scale and clamp. Depends on pcrt_pkg, pcrt_if.
module pcrt_datapath import pcrt_pkg::*; #(
  parameter bit USE_EXT = USE_EXT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 busy,
  input  rot_mat_t             rot,
  input  logic signed [TW-1:0] shift [0:2],
  input  logic [SW-1:0]        scale,
  pcrt_in_if.sink              pin,
  pcrt_out_if.source           pout
);
  localparam int PRW = OW + 1;

  logic v1, v2, v3, v4, v5;
  logic adv, take;
  colour_t c1, c2, c3, c4, c5;
  logic signed [QQW-1:0] q_next [0:2];
  logic signed [QQW-1:0] q2 [0:2];
  logic signed [ACW-1:0] rp [0:2][0:2];
  logic signed [ACW-1:0] acc2 [0:2];
  logic signed [UW-1:0]  u4 [0:2];
  logic signed [PRW-1:0] prod [0:2];
  logic signed [OW-1:0]  res [0:2];
  logic signed [CW-1:0]  p_in [0:2];

  localparam logic signed [PRW-1:0] OMAX = $signed({2'b00, {(OW-1){1'b1}}});
  localparam logic signed [PRW-1:0] OMIN = $signed({2'b11, {(OW-1){1'b0}}});

  assign adv       = !v5 || pout.ready;
  assign pin.ready = adv && !busy;
  assign take      = pin.valid && pin.ready;
  assign p_in[0]   = pin.pos_x;
  assign p_in[1]   = pin.pos_y;
  assign p_in[2]   = pin.pos_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5} <= '0;
    end else if (adv) begin
      {v1, v2, v3, v4, v5} <= {take, v1, v2, v3, v4};
    end
  end

  generate
    if (USE_EXT) begin : g_ext
      logic signed [EW+CW-1:0] ep [0:2][0:2];
      logic signed [ACW-1:0]   acc1 [0:2];
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              ep[i][j] <= EXT[i][j] * p_in[j];
            end
          end
        end
      end
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          acc1[i] = ACW'(ep[i][0]) + ACW'(ep[i][1]) + ACW'(ep[i][2])
                  + (ACW'(EXT[i][3]) <<< 16) + (64'sd1 <<< (FRAC - 1));
          q_next[i] = QQW'(acc1[i] >>> FRAC);
        end
      end
    end else begin : g_pass
      logic signed [CW-1:0] p1 [0:2];
      always_ff @(posedge clk) begin
        if (adv) p1 <= p_in;
      end
      always_comb begin
        for (int i = 0; i < 3; i++) q_next[i] = QQW'(p1[i]);
      end
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc2[i] = rp[i][0] + rp[i][1] + rp[i][2] + (64'sd1 <<< (FRAC - 1));
      prod[i] = $signed({1'b0, scale}) * u4[i];
      if (prod[i] > OMAX) res[i] = OMAX[OW-1:0];
      else if (prod[i] < OMIN) res[i] = OMIN[OW-1:0];
      else res[i] = prod[i][OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= '{red: pin.red, green: pin.green, blue: pin.blue, alpha: pin.alpha};
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      c5 <= c4;
      q2 <= q_next;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rp[i][j] <= $signed(rot[3*i+j]) * q2[j];
        end
        u4[i] <= UW'(acc2[i] >>> FRAC) + UW'(shift[i]);
      end
      pout.out_x <= res[0];
      pout.out_y <= res[1];
      pout.out_z <= res[2];
    end
  end

  assign pout.valid     = v5;
  assign pout.out_red   = c5.red;
  assign pout.out_green = c5.green;
  assign pout.out_blue  = c5.blue;
  assign pout.out_alpha = c5.alpha;

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |-> !busy) else $error("point taken during matrix rebuild");
  a_out_from_s4: assert property (@(posedge clk) disable iff (rst)
    $rose(v5) |-> $past(v4)) else $error("output valid without stage 4");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v4 && !adv) |=> (v4 && $stable(u4[0]))) else $error("stage 4 lost on stall");
endmodule

>>> hdl/point_cloud_rigid_transform.sv
// Throughput: one point per cycle while no output stall or matrix rebuild
// holds the input, set by the five-stage multiply pipeline; its last stage
// registers the result. A quaternion write rebuilds the rotation matrix in
// the serial divider (identity if all zero), with input not ready meanwhile.
// Reset (synchronous): pose to identity, shift 0, scale 1, pipeline empty.
module point_cloud_rigid_transform import pcrt_pkg::*; #(
  parameter bit USE_FIXED_EXTRINSIC = USE_EXT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data,
  pcrt_in_if.sink           points_in,
  pcrt_out_if.source        points_out
);
  logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [TW-1:0] shift [0:2];
  logic [SW-1:0]        scale_factor;
  logic                 quat_wr;
  logic                 busy;
  rot_mat_t             rot;

  assign quat_wr = cfg_we && (cfg_addr == REG_QUAT_W || cfg_addr == REG_QUAT_X ||
                              cfg_addr == REG_QUAT_Y || cfg_addr == REG_QUAT_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w       <= 16'sd16384;
      quat_x       <= '0;
      quat_y       <= '0;
      quat_z       <= '0;
      shift        <= '{default: '0};
      scale_factor <= SW'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_QUAT_W:  quat_w <= $signed(cfg_data[QW-1:0]);
        REG_QUAT_X:  quat_x <= $signed(cfg_data[QW-1:0]);
        REG_QUAT_Y:  quat_y <= $signed(cfg_data[QW-1:0]);
        REG_QUAT_Z:  quat_z <= $signed(cfg_data[QW-1:0]);
        REG_SHIFT_X: shift[0] <= $signed(cfg_data[TW-1:0]);
        REG_SHIFT_Y: shift[1] <= $signed(cfg_data[TW-1:0]);
        REG_SHIFT_Z: shift[2] <= $signed(cfg_data[TW-1:0]);
        REG_SCALE:   scale_factor <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  pcrt_rot_builder u_rot (
    .clk   (clk),
    .rst   (rst),
    .start (quat_wr),
    .qw    (quat_w),
    .qx    (quat_x),
    .qy    (quat_y),
    .qz    (quat_z),
    .rot   (rot),
    .busy  (busy)
  );

  pcrt_datapath #(.USE_EXT(USE_FIXED_EXTRINSIC)) u_dp (
    .clk   (clk),
    .rst   (rst),
    .busy  (busy),
    .rot   (rot),
    .shift (shift),
    .scale (scale_factor),
    .pin   (points_in),
    .pout  (points_out)
  );
endmodule

>>> verif/tb.sv
// Self-checking testbench for point_cloud_rigid_transform: directed table, then random poses.
// Depends on pcrt_pkg and the point stream interfaces in hdl/pcrt_if.sv.
module tb import pcrt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE = 8;

  typedef struct {
    logic signed [QW-1:0] w, x, y, z;
    logic signed [TW-1:0] tx, ty, tz;
    logic [SW-1:0]        s;
  } pose_t;

  typedef struct {
    logic signed [CW-1:0] px, py, pz;
    colour_t              col;
  } point_t;

  typedef struct {
    logic signed [OW-1:0] ox, oy, oz;
    colour_t              col;
  } xform_t;

  typedef struct {
    int     pose_sel;
    point_t pt;
    bit     typed;   // expected result given in the row
    xform_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_data;

  pcrt_in_if  pin();
  pcrt_out_if pout();

  point_cloud_rigid_transform u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .points_in(pin), .points_out(pout)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pose_t  cur_pose;
  xform_t pending[$];
  int     errors = 0;
  int     n_sent = 0;
  int     n_recv = 0;
  int     n_poses = 0;
  int     gap_pct = 0;
  int     stall_pct = 0;
  bit     hold_req = 1'b0;
  int     hold_cnt = 0;
  int     idle_cnt = 0;

  // ---------------- predictor ----------------
  function automatic logic signed [95:0] ext_q29(logic [63:0] digits, bit neg);
    logic [63:0] t;
    t = (digits * 64'd16384 + 64'd15258789062) / 64'd30517578125;
    return neg ? -$signed({32'd0, t}) : $signed({32'd0, t});
  endfunction

  function automatic logic signed [95:0] rot_q29(logic signed [95:0] num,
                                                 logic signed [95:0] n);
    logic signed [95:0] mag, q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< FRAC) + n / 2) / n;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [OW-1:0] clamp48(logic signed [95:0] v);
    logic signed [95:0] hi, lo;
    hi = (96'sd1 <<< (OW - 1)) - 1;
    lo = -(96'sd1 <<< (OW - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OW-1:0];
  endfunction

  function automatic xform_t transform_point(point_t p, pose_t ps);
    logic signed [95:0] e[3][4];
    logic signed [95:0] r[3][3];
    logic signed [95:0] pv[3], qv[3], tv[3], u[3];
    logic signed [95:0] w, x, y, z, n, acc, sc;
    xform_t o;
    e[0][0] = ext_q29(64'd241761029007299, 0); e[0][1] = ext_q29(64'd156482265388292, 1);
    e[0][2] = ext_q29(64'd957635058606503, 0); e[0][3] = ext_q29(64'd78542236056188, 0);
    e[1][0] = ext_q29(64'd159587283912986, 1); e[1][1] = ext_q29(64'd979884124280077, 1);
    e[1][2] = ext_q29(64'd119829052391907, 1); e[1][3] = ext_q29(64'd78052590612562, 1);
    e[2][0] = ext_q29(64'd957122512360151, 0); e[2][1] = ext_q29(64'd123856382971628, 1);
    e[2][2] = ext_q29(64'd261870373907737, 1); e[2][3] = ext_q29(64'd61252007077847, 1);
    w = ps.w; x = ps.x; y = ps.y; z = ps.z;
    n = w*w + x*x + y*y + z*z;
    if (n == 0) begin
      foreach (r[i, j]) r[i][j] = (i == j) ? (96'sd1 <<< FRAC) : 96'sd0;
    end else begin
      r[0][0] = rot_q29(w*w + x*x - y*y - z*z, n);
      r[0][1] = rot_q29(2*(x*y - w*z), n);
      r[0][2] = rot_q29(2*(x*z + w*y), n);
      r[1][0] = rot_q29(2*(x*y + w*z), n);
      r[1][1] = rot_q29(w*w - x*x + y*y - z*z, n);
      r[1][2] = rot_q29(2*(y*z - w*x), n);
      r[2][0] = rot_q29(2*(x*z - w*y), n);
      r[2][1] = rot_q29(2*(y*z + w*x), n);
      r[2][2] = rot_q29(w*w - x*x - y*y + z*z, n);
    end
    pv[0] = p.px; pv[1] = p.py; pv[2] = p.pz;
    tv[0] = ps.tx; tv[1] = ps.ty; tv[2] = ps.tz;
    for (int i = 0; i < 3; i++) begin
      acc = e[i][3] * 65536;
      for (int j = 0; j < 3; j++) acc += e[i][j] * pv[j];
      qv[i] = (acc + (96'sd1 <<< (FRAC - 1))) >>> FRAC;
    end
    sc = $signed({86'd0, ps.s});
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += r[i][j] * qv[j];
      u[i] = sc * (((acc + (96'sd1 <<< (FRAC - 1))) >>> FRAC) + tv[i]);
    end
    o.ox = clamp48(u[0]); o.oy = clamp48(u[1]); o.oz = clamp48(u[2]);
    o.col = p.col;
    return o;
  endfunction

  // ---------------- configuration ----------------
  task automatic settle();
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx <= REG_QUAT_Z) begin
      // rotation matrix rebuild holds the input off
      repeat (3) @(posedge clk);
      while (!pin.ready) @(posedge clk);
    end
  endtask

  task automatic load_pose(pose_t ps);
    settle();
    write_reg(REG_QUAT_W, {16'd0, ps.w});
    write_reg(REG_QUAT_X, {16'd0, ps.x});
    write_reg(REG_QUAT_Y, {16'd0, ps.y});
    write_reg(REG_QUAT_Z, {16'd0, ps.z});
    write_reg(REG_SHIFT_X, ps.tx);
    write_reg(REG_SHIFT_Y, ps.ty);
    write_reg(REG_SHIFT_Z, ps.tz);
    write_reg(REG_SCALE, {22'd0, ps.s});
    cur_pose = ps;
    n_poses++;
  endtask

  // ---------------- point sender ----------------
  task automatic send_point(point_t p, bit typed, xform_t res);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      pin.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    pin.valid <= 1'b1;
    pin.pos_x <= p.px; pin.pos_y <= p.py; pin.pos_z <= p.pz;
    pin.red <= p.col.red; pin.green <= p.col.green;
    pin.blue <= p.col.blue; pin.alpha <= p.col.alpha;
    do @(posedge clk); while (!pin.ready);
    pending = {pending, (typed ? res : transform_point(p, cur_pose))};
    n_sent++;
  endtask

  function automatic logic [31:0] rand_coord();
    int k;
    k = $urandom_range(99);
    if (k < 65) return $urandom();
    if (k < 88) return 32'($signed($urandom_range(2097151)) - 1048576);
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t ps;
    ps.w = QW'($urandom()); ps.x = QW'($urandom());
    ps.y = QW'($urandom()); ps.z = QW'($urandom());
    ps.tx = $urandom(); ps.ty = $urandom(); ps.tz = $urandom();
    ps.s = SW'($urandom_range(1023));
    return ps;
  endfunction

  // ---------------- result receiver ----------------
  task automatic check_result();
    xform_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected transaction x=%h y=%h z=%h", $time,
               pout.out_x, pout.out_y, pout.out_z);
      errors++;
      return;
    end
    e = pending.pop_front();
    n_recv++;
    if (pout.out_x !== e.ox) begin
      $display("%0t: out_x expected %h actual %h", $time, e.ox, pout.out_x); errors++;
    end
    if (pout.out_y !== e.oy) begin
      $display("%0t: out_y expected %h actual %h", $time, e.oy, pout.out_y); errors++;
    end
    if (pout.out_z !== e.oz) begin
      $display("%0t: out_z expected %h actual %h", $time, e.oz, pout.out_z); errors++;
    end
    if ({pout.out_red, pout.out_green, pout.out_blue, pout.out_alpha} !== e.col) begin
      $display("%0t: colour expected %h actual %h", $time, e.col,
               {pout.out_red, pout.out_green, pout.out_blue, pout.out_alpha});
      errors++;
    end
  endtask

  initial begin
    pout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (pout.valid && pout.ready) check_result();
      if (hold_cnt > 0) begin
        pout.ready <= 1'b0;
        hold_cnt--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES - 1;
        pout.ready <= 1'b0;
      end else begin
        pout.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog on transaction activity
  always @(posedge clk) begin
    if ((pin.valid && pin.ready) || (pout.valid && pout.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  row_t   rows[$];
  pose_t  poses[$];
  pose_t  ps;
  point_t pt;
  xform_t zres;
  int     sel;
  int     k;

  function automatic row_t mk_row(int psel, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  logic [31:0] col, bit typed);
    row_t r;
    r.pose_sel = psel;
    r.pt.px = x; r.pt.py = y; r.pt.pz = z; r.pt.col = col;
    r.typed = typed;
    r.res.ox = '0; r.res.oy = '0; r.res.oz = '0; r.res.col = col;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    rows = {rows, r};
  endfunction

  function automatic void add_pose(pose_t p);
    poses = {poses, p};
  endfunction

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0; cfg_addr <= '0; cfg_data <= '0;
    pin.valid <= 1'b0;
    pin.pos_x <= '0; pin.pos_y <= '0; pin.pos_z <= '0;
    pin.red <= '0; pin.green <= '0; pin.blue <= '0; pin.alpha <= '0;
    cur_pose = '{w: 16384, x: 0, y: 0, z: 0, tx: 0, ty: 0, tz: 0, s: 1};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed poses: reset values, zero quaternion with zero and full scale, extremes, unnormalised
    add_pose(cur_pose);
    add_pose('{w: 0, x: 0, y: 0, z: 0, tx: 32'h7fffffff, ty: 32'h80000000,
               tz: 32'h12345678, s: 0});
    add_pose('{w: 0, x: 0, y: 0, z: 0, tx: 32'h7fffffff, ty: 32'h80000000,
               tz: 32'h7fffffff, s: 1023});
    add_pose('{w: -32768, x: -32768, y: -32768, z: -32768, tx: 32'h80000000,
               ty: 32'h80000000, tz: 32'h80000000, s: 1023});
    add_pose('{w: 32767, x: 1, y: -1, z: 0, tx: 0, ty: 0, tz: 0, s: 1});

    add_row(mk_row(0, 0, 0, 0, 32'h00000000, 0));
    add_row(mk_row(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 0));
    add_row(mk_row(0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h01020304, 0));
    add_row(mk_row(0, 32'h7fffffff, 32'h80000000, 32'h00010000, 32'h80402010, 0));
    add_row(mk_row(0, 32'hffffffff, 32'h00000001, 32'hffff0000, 32'haa55aa55, 0));
    // zero scale: position forced to zero, colour passes through
    add_row(mk_row(1, 0, 0, 0, 32'hffffffff, 1));
    add_row(mk_row(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h00000000, 1));
    add_row(mk_row(1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h5aa55aa5, 1));
    add_row(mk_row(1, 32'h12345678, 32'hedcba987, 32'h00000000, 32'h0f0f0f0f, 1));
    // zero quaternion as identity, full scale, extremes
    add_row(mk_row(2, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h11223344, 0));
    add_row(mk_row(2, 32'h80000000, 32'h80000000, 32'h80000000, 32'h55667788, 0));
    add_row(mk_row(2, 0, 0, 0, 32'h99aabbcc, 0));
    add_row(mk_row(3, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hddeeff00, 0));
    add_row(mk_row(3, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h10203040, 0));
    add_row(mk_row(3, 0, 0, 0, 32'hfedcba98, 0));
    // unnormalised quaternion
    add_row(mk_row(4, 32'h00010000, 32'h00020000, 32'hfffd0000, 32'h76543210, 0));
    add_row(mk_row(4, 32'h7fffffff, 32'h80000000, 32'h00000000, 32'h01010101, 0));

    sel = 0;
    foreach (rows[i]) begin
      if (rows[i].pose_sel != sel) begin
        sel = rows[i].pose_sel;
        pin.valid <= 1'b0;
        load_pose(poses[sel]);
      end
      send_point(rows[i].pt, rows[i].typed, rows[i].res);
    end
    pin.valid <= 1'b0;

    // random part: a new pose per phase, idling pattern cycles through four modes
    for (int ph = 0; ph < 13; ph++) begin
      case (ph)
        0: ps = poses[0];
        3: ps = poses[3];
        5: ps = poses[2];
        7: begin ps = rand_pose(); ps.s = 0; end
        9: begin ps = rand_pose(); ps.w = 0; ps.x = 0; ps.y = 0; ps.z = 0; end
        11: begin ps = rand_pose(); ps.s = 1023; end
        default: ps = rand_pose();
      endcase
      load_pose(ps);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 13; stall_pct = 13; end
      endcase
      if (ph == 4) hold_req = 1'b1;
      k = 50;
      repeat (k) begin
        pt.px = rand_coord(); pt.py = rand_coord(); pt.pz = rand_coord();
        pt.col = $urandom();
        send_point(pt, 1'b0, zres);
      end
      pin.valid <= 1'b0;
    end
    gap_pct = 0;
    stall_pct = 0;

    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE * 2) @(posedge clk);
    $display("Covered %0d points over %0d poses, %0d results checked.", n_sent, n_poses,
             n_recv);
    $display("Poses included identity, zero quaternion, zero and full scale, extreme shifts.");
    if (errors == 0 && pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> point_cloud_rigid_transform.f
hdl/pcrt_pkg.sv
hdl/pcrt_if.sv
hdl/pcrt_rot_builder.sv
hdl/pcrt_datapath.sv
hdl/point_cloud_rigid_transform.sv
verif/tb.sv
